// File: rtl/drs_pkg.sv
// Shared types and constants of the disk request scheduler.
package drs_pkg;

  // Fixed field widths of the request and result words.
  localparam int BLK_W     = 24;
  localparam int PRIO_W    = 3;
  localparam int TAG_W     = 8;
  localparam int DELAY_W   = 16;
  localparam int LAT_W     = 25;
  localparam int CNT_OUT_W = 5;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  // Operation codes of an input word.
  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // Policy codes.
  localparam logic POL_FCFS = 1'b0;
  localparam logic POL_SSTF = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_DELAY = 1'd1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } drs_state_t;

endpackage

// File: rtl/disk_request_scheduler_core.sv
// Disk request queue held in a synchronous memory, with an FCFS or SSTF dispatch sequencer.
// Enqueue, queue-full and queue-empty words go straight to S_FINISH, which loads their result
// once the result register is free. A dispatch scans the queued entries one per cycle through
// the single memory read port (one entry under FCFS, all of them under SSTF), then closes the
// gap one entry per cycle. One word is in work at a time; a new word is taken while a finished
// result waits. Synchronous active-low reset empties the queue, homes the head and clears both
// registers.
module disk_request_scheduler_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int BLOCK_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration port
  input  logic                              cfg_we,
  input  logic [drs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drs_pkg::DELAY_W-1:0]       cfg_wdata,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [drs_pkg::BLK_W-1:0]         in_block_number,
  input  logic [drs_pkg::PRIO_W-1:0]        in_priority_req,
  input  logic [drs_pkg::TAG_W-1:0]         in_owner_tag,
  input  logic                              in_is_write,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [drs_pkg::STATUS_W-1:0]      out_status,
  output logic [drs_pkg::BLK_W-1:0]         out_served_block,
  output logic [drs_pkg::TAG_W-1:0]         out_served_tag,
  output logic                              out_served_write,
  output logic [drs_pkg::LAT_W-1:0]         out_latency,
  output logic [drs_pkg::CNT_OUT_W-1:0]     out_queue_count
);

  // Stored block width never exceeds the block field.
  localparam int SB = (BLOCK_BITS < drs_pkg::BLK_W) ? BLOCK_BITS : drs_pkg::BLK_W;
  localparam int EW = SB + drs_pkg::PRIO_W + drs_pkg::TAG_W + 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int PRIO_LO = drs_pkg::TAG_W + 1;

  drs_pkg::drs_state_t state_r, state_nxt;

  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [SB-1:0]                   head_r, head_nxt;
  logic                            policy_r, policy_nxt;
  logic [drs_pkg::DELAY_W-1:0]     rot_r, rot_nxt;
  logic [CW-1:0]                   iss_r, iss_nxt;
  logic [CW-1:0]                   sh_r, sh_nxt;
  logic                            rdv_r, rdv_nxt;
  logic [IW-1:0]                   ridx_r, ridx_nxt;
  logic [IW-1:0]                   best_idx_r, best_idx_nxt;
  logic [SB-1:0]                   best_d_r, best_d_nxt;
  logic [drs_pkg::PRIO_W-1:0]      best_prio_r, best_prio_nxt;
  logic [SB-1:0]                   best_blk_r, best_blk_nxt;
  logic [drs_pkg::TAG_W-1:0]       best_tag_r, best_tag_nxt;
  logic                            best_wr_r, best_wr_nxt;
  logic [drs_pkg::STATUS_W-1:0]    res_status_r, res_status_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [drs_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [drs_pkg::BLK_W-1:0]       out_blk_r, out_blk_nxt;
  logic [drs_pkg::TAG_W-1:0]       out_tag_r, out_tag_nxt;
  logic                            out_wr_r, out_wr_nxt;
  logic [drs_pkg::LAT_W-1:0]       out_lat_r, out_lat_nxt;
  logic [drs_pkg::CNT_OUT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic                            out_load;

  // Queue memory with one write and one registered read port.
  logic [EW-1:0]                   mem [QUEUE_DEPTH];
  logic [EW-1:0]                   mem_q;
  logic                            rd_en, wr_en;
  logic [IW-1:0]                   rd_addr, wr_addr;
  logic [EW-1:0]                   wr_data;

  logic                            in_acc;
  logic [CW-1:0]                   lim;
  logic [SB-1:0]                   cand_blk, cand_d;
  logic [drs_pkg::PRIO_W-1:0]      cand_prio;
  logic                            take;
  logic [IW-1:0]                   fin_idx;
  logic [drs_pkg::LAT_W:0]         lat_sum;
  logic [CW+drs_pkg::CNT_OUT_W-1:0] cnt_ext;

  assign in_stall = (state_r != drs_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign lim      = (policy_r == drs_pkg::POL_SSTF) ? cnt_r : CW'(1);

  // Candidate entry arriving from the memory and its seek distance.
  assign cand_blk  = mem_q[EW-1 -: SB];
  assign cand_prio = mem_q[PRIO_LO +: drs_pkg::PRIO_W];
  assign cand_d    = (cand_blk >= head_r) ? (cand_blk - head_r) : (head_r - cand_blk);
  assign take      = (ridx_r == '0) || (cand_d < best_d_r) ||
                     ((cand_d == best_d_r) && (cand_prio > best_prio_r));
  assign fin_idx   = take ? ridx_r : best_idx_r;

  // Latency is seek distance plus rotational delay, saturated to the field.
  assign lat_sum = (drs_pkg::LAT_W + 1)'(best_d_r) + (drs_pkg::LAT_W + 1)'(rot_r);
  assign cnt_ext = {{drs_pkg::CNT_OUT_W{1'b0}}, cnt_r};

  // Configuration registers.
  always_comb begin
    policy_nxt = policy_r;
    rot_nxt    = rot_r;
    if (cfg_we) begin
      case (cfg_index)
        drs_pkg::CFG_POLICY:    policy_nxt = cfg_wdata[0];
        drs_pkg::CFG_ROT_DELAY: rot_nxt    = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: accept, scan for the pick, compact the queue, deliver.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    iss_nxt        = iss_r;
    sh_nxt         = sh_r;
    rdv_nxt        = 1'b0;
    ridx_nxt       = ridx_r;
    best_idx_nxt   = best_idx_r;
    best_d_nxt     = best_d_r;
    best_prio_nxt  = best_prio_r;
    best_blk_nxt   = best_blk_r;
    best_tag_nxt   = best_tag_r;
    best_wr_nxt    = best_wr_r;
    res_status_nxt = res_status_r;
    rd_en          = 1'b0;
    rd_addr        = iss_r[IW-1:0];
    wr_en          = 1'b0;
    wr_addr        = cnt_r[IW-1:0];
    wr_data        = {in_block_number[SB-1:0], in_priority_req, in_owner_tag, in_is_write};
    out_load       = 1'b0;

    case (state_r)
      drs_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = drs_pkg::S_FINISH;
          if (in_operation == drs_pkg::OP_ENQUEUE) begin
            if (cnt_r == CW'(QUEUE_DEPTH)) begin
              res_status_nxt = drs_pkg::ST_FULL;
            end else begin
              wr_en          = 1'b1;
              cnt_nxt        = cnt_r + CW'(1);
              res_status_nxt = drs_pkg::ST_ENQUEUED;
            end
          end else if (cnt_r == '0) begin
            res_status_nxt = drs_pkg::ST_EMPTY;
          end else begin
            iss_nxt   = '0;
            state_nxt = drs_pkg::S_SCAN;
          end
        end
      end

      drs_pkg::S_SCAN: begin
        // Issue one read per cycle until the scan limit.
        if (iss_r < lim) begin
          rd_en    = 1'b1;
          rd_addr  = iss_r[IW-1:0];
          rdv_nxt  = 1'b1;
          ridx_nxt = iss_r[IW-1:0];
          iss_nxt  = iss_r + CW'(1);
        end
        // Compare the entry read in the previous cycle.
        if (rdv_r) begin
          if (take) begin
            best_idx_nxt  = ridx_r;
            best_d_nxt    = cand_d;
            best_prio_nxt = cand_prio;
            best_blk_nxt  = cand_blk;
            best_tag_nxt  = mem_q[1 +: drs_pkg::TAG_W];
            best_wr_nxt   = mem_q[0];
          end
          if (CW'(ridx_r) == lim - CW'(1)) begin
            sh_nxt    = CW'(fin_idx) + CW'(1);
            state_nxt = drs_pkg::S_SHIFT;
          end
        end
      end

      drs_pkg::S_SHIFT: begin
        // Read entry i+1 now, write it to entry i next cycle.
        if (sh_r < cnt_r) begin
          rd_en    = 1'b1;
          rd_addr  = sh_r[IW-1:0];
          rdv_nxt  = 1'b1;
          ridx_nxt = sh_r[IW-1:0] - IW'(1);
          sh_nxt   = sh_r + CW'(1);
        end
        if (rdv_r) begin
          wr_en   = 1'b1;
          wr_addr = ridx_r;
          wr_data = mem_q;
        end else if (sh_r >= cnt_r) begin
          cnt_nxt        = cnt_r - CW'(1);
          head_nxt       = best_blk_r;
          res_status_nxt = drs_pkg::ST_DISPATCHED;
          state_nxt      = drs_pkg::S_FINISH;
        end
      end

      drs_pkg::S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = drs_pkg::S_IDLE;
        end
      end

      default: state_nxt = drs_pkg::S_IDLE;
    endcase
  end

  // Result word assembly.
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = res_status_r;
    out_blk_nxt    = '0;
    out_tag_nxt    = '0;
    out_wr_nxt     = 1'b0;
    out_lat_nxt    = '0;
    out_cnt_nxt    = cnt_ext[drs_pkg::CNT_OUT_W-1:0];
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
    if (res_status_r == drs_pkg::ST_DISPATCHED) begin
      out_blk_nxt = drs_pkg::BLK_W'(best_blk_r);
      out_tag_nxt = best_tag_r;
      out_wr_nxt  = best_wr_r;
      out_lat_nxt = lat_sum[drs_pkg::LAT_W] ? {drs_pkg::LAT_W{1'b1}}
                                            : lat_sum[drs_pkg::LAT_W-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drs_pkg::S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      policy_r    <= drs_pkg::POL_FCFS;
      rot_r       <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      policy_r    <= policy_nxt;
      rot_r       <= rot_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    iss_r        <= iss_nxt;
    sh_r         <= sh_nxt;
    ridx_r       <= ridx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_d_r     <= best_d_nxt;
    best_prio_r  <= best_prio_nxt;
    best_blk_r   <= best_blk_nxt;
    best_tag_r   <= best_tag_nxt;
    best_wr_r    <= best_wr_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_blk_r    <= out_blk_nxt;
      out_tag_r    <= out_tag_nxt;
      out_wr_r     <= out_wr_nxt;
      out_lat_r    <= out_lat_nxt;
      out_cnt_r    <= out_cnt_nxt;
    end
  end

  // Queue memory write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Queue memory read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_served_block = out_blk_r;
  assign out_served_tag   = out_tag_r;
  assign out_served_write = out_wr_r;
  assign out_latency      = out_lat_r;
  assign out_queue_count  = out_cnt_r;

  // The fill count never passes the queue depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // Compaction writes stay below the last occupied entry.
  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == drs_pkg::S_SHIFT) |-> (CW'(wr_addr) < cnt_r - CW'(1)))
    else $error("compaction write outside the queue");

  // The head only moves when a dispatch completes.
  a_head_move: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != $past(head_r)) |-> ($past(state_r) == drs_pkg::S_SHIFT))
    else $error("head moved outside a dispatch");

  // A result register still held by a stall is never overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("result overwritten while stalled");

  // Each scan picks an occupied entry.
  a_pick_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == drs_pkg::S_SHIFT) |-> (CW'(best_idx_r) < cnt_r))
    else $error("picked entry beyond the queue");

endmodule

// File: tb/sv/disk_request_scheduler_core_tb.sv
// Self-checking testbench of the disk request scheduler core, with its own queue predictor.
module disk_request_scheduler_core_tb;
  import drs_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int STALL_LIMIT = 2000;
  localparam logic [LAT_W-1:0] LAT_MAX = {LAT_W{1'b1}};

  // One queued disk request as the predictor holds it.
  typedef struct {
    logic [BLK_W-1:0]  blk;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    logic              wr;
  } queued_req_t;

  // One result word as the block should return it.
  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [BLK_W-1:0]     blk;
    logic [TAG_W-1:0]     tag;
    logic                 wr;
    logic [LAT_W-1:0]     lat;
    logic [CNT_OUT_W-1:0] count;
  } sched_result_t;

  // Queue predictor and the list of result words still owed by the block.
  class sched_scoreboard;
    queued_req_t        slots [QDEPTH];
    int unsigned        held;
    logic [BLK_W-1:0]   head;
    logic               policy;
    logic [DELAY_W-1:0] rot_delay;
    sched_result_t      awaited [$];
    int unsigned        errors, n_enq, n_full, n_empty, n_fcfs, n_sstf, n_cfg;

    function new();
      held      = 0;
      head      = '0;
      policy    = POL_FCFS;
      rot_delay = '0;
      errors    = 0;
      n_enq     = 0;
      n_full    = 0;
      n_empty   = 0;
      n_fcfs    = 0;
      n_sstf    = 0;
      n_cfg     = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [DELAY_W-1:0] data);
      n_cfg++;
      case (idx)
        CFG_POLICY:    policy = data[0];
        CFG_ROT_DELAY: rot_delay = data;
        default: ;
      endcase
    endfunction

    function logic [BLK_W-1:0] head_gap(logic [BLK_W-1:0] b);
      return (b >= head) ? b - head : head - b;
    endfunction

    // Apply one accepted request word to the predicted queue and note its result.
    function void note_request(logic op, logic [BLK_W-1:0] blk, logic [PRIO_W-1:0] prio,
                               logic [TAG_W-1:0] tag, logic wr);
      sched_result_t    r;
      int               pick;
      logic [BLK_W-1:0] best_gap;
      logic [LAT_W:0]   sum;
      r.status = ST_ENQUEUED;
      r.blk    = '0;
      r.tag    = '0;
      r.wr     = 1'b0;
      r.lat    = '0;
      if (op == OP_ENQUEUE) begin
        if (held >= QDEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          slots[held].blk  = blk;
          slots[held].prio = prio;
          slots[held].tag  = tag;
          slots[held].wr   = wr;
          held++;
          n_enq++;
        end
      end else if (held == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        // Oldest entry first; under shortest seek the nearest wins, then priority, then age.
        pick = 0;
        if (policy == POL_SSTF) begin
          best_gap = head_gap(slots[0].blk);
          for (int i = 1; i < held; i++) begin
            if (head_gap(slots[i].blk) < best_gap ||
                (head_gap(slots[i].blk) == best_gap && slots[i].prio > slots[pick].prio)) begin
              best_gap = head_gap(slots[i].blk);
              pick = i;
            end
          end
          n_sstf++;
        end else begin
          n_fcfs++;
        end
        sum = head_gap(slots[pick].blk) + rot_delay;
        r.lat    = (sum > LAT_MAX) ? LAT_MAX : sum[LAT_W-1:0];
        r.blk    = slots[pick].blk;
        r.tag    = slots[pick].tag;
        r.wr     = slots[pick].wr;
        r.status = ST_DISPATCHED;
        head     = slots[pick].blk;
        // Close the gap left by the served entry.
        for (int i = pick; i + 1 < held; i++) slots[i] = slots[i + 1];
        held--;
      end
      r.count = CNT_OUT_W'(held);
      awaited.push_back(r);
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result word with the oldest one owed.
    function void check_result(logic [STATUS_W-1:0] status, logic [BLK_W-1:0] blk,
                               logic [TAG_W-1:0] tag, logic wr, logic [LAT_W-1:0] lat,
                               logic [CNT_OUT_W-1:0] count);
      sched_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: result word with none owed: expected nothing, actual status %0d",
                 $time, status);
        errors++;
        return;
      end
      e = awaited.pop_front();
      compare_field("status", e.status, status);
      compare_field("served_block", e.blk, blk);
      compare_field("served_tag", e.tag, tag);
      compare_field("served_write", e.wr, wr);
      compare_field("latency", e.lat, lat);
      compare_field("queue_count", e.count, count);
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_POLICY;
  logic [DELAY_W-1:0]    cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_operation = OP_ENQUEUE;
  logic [BLK_W-1:0]      in_block_number = '0;
  logic [PRIO_W-1:0]     in_priority_req = '0;
  logic [TAG_W-1:0]      in_owner_tag = '0;
  logic                  in_is_write = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [BLK_W-1:0]      out_served_block;
  logic [TAG_W-1:0]      out_served_tag;
  logic                  out_served_write;
  logic [LAT_W-1:0]      out_latency;
  logic [CNT_OUT_W-1:0]  out_queue_count;

  sched_scoreboard sb;
  bit              quiet_phase = 1'b0;
  int              idle_cycles = 0;

  disk_request_scheduler_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_block_number  (in_block_number),
    .in_priority_req  (in_priority_req),
    .in_owner_tag     (in_owner_tag),
    .in_is_write      (in_is_write),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_served_block (out_served_block),
    .out_served_tag   (out_served_tag),
    .out_served_write (out_served_write),
    .out_latency      (out_latency),
    .out_queue_count  (out_queue_count)
  );

  // Clock with a period of 12 time units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result monitor: a word moves at an edge where valid is high and stall is low.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(out_status, out_served_block, out_served_tag, out_served_write,
                      out_latency, out_queue_count);
    end
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("disk_request_scheduler_core_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver back-pressure: random stall bursts, with the odd long clear stretch.
  initial begin
    int n;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (quiet_phase) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = $urandom_range(0, 9);
        if (n < 4) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ((n == 9) ? 40 : $urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Present one request word and hold it until the block takes it.
  task automatic send_word(input logic op, input logic [BLK_W-1:0] blk,
                           input logic [PRIO_W-1:0] prio, input logic [TAG_W-1:0] tag,
                           input logic wr);
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_block_number <= blk;
    in_priority_req <= prio;
    in_owner_tag    <= tag;
    in_is_write     <= wr;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(op, blk, prio, tag, wr);
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off the sender until every owed result word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers while the block is idle.
  task automatic set_config(input logic [DELAY_W-1:0] pol_word,
                            input logic [DELAY_W-1:0] delay_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POLICY;
    cfg_wdata <= pol_word;
    @(posedge clk);
    sb.write_register(CFG_POLICY, pol_word);
    cfg_index <= CFG_ROT_DELAY;
    cfg_wdata <= delay_word;
    @(posedge clk);
    sb.write_register(CFG_ROT_DELAY, delay_word);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random request word; four in ten blocks cluster near one base so that seek ties are common.
  task automatic send_random(input int enq_pct, input logic [BLK_W-1:0] cluster);
    logic             op;
    logic [BLK_W-1:0] b;
    int               pick;
    op   = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DISPATCH;
    pick = $urandom_range(0, 9);
    if (pick < 4)       b = cluster + BLK_W'($urandom_range(0, 15));
    else if (pick < 8)  b = BLK_W'($urandom);
    else if (pick == 8) b = '0;
    else                b = '1;
    send_word(op, b, PRIO_W'($urandom_range(0, 7)), TAG_W'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic             pol_bit;
    logic [DELAY_W-1:0] delay_word;
    int               gap_pct;
    int               enq_pct;
    logic [BLK_W-1:0] cluster;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: empty dispatch, then the two block extremes served oldest first.
    send_word(OP_DISPATCH, '0, '0, '0, 1'b0);
    send_word(OP_ENQUEUE, '1, 3'd7, 8'hFF, 1'b1);
    send_word(OP_ENQUEUE, '0, 3'd0, 8'h00, 1'b0);
    send_word(OP_DISPATCH, '0, '0, '0, 1'b0);
    send_word(OP_DISPATCH, '0, '0, '0, 1'b0);

    // Shortest seek with the largest delay: equal distances settled by priority, then age.
    drain_results();
    set_config(16'hFFFF, 16'hFFFF);
    send_word(OP_ENQUEUE, 24'd100, 3'd2, 8'h01, 1'b0);
    send_word(OP_ENQUEUE, 24'd100, 3'd5, 8'h02, 1'b1);
    send_word(OP_ENQUEUE, 24'd100, 3'd5, 8'h03, 1'b0);
    send_word(OP_ENQUEUE, 24'd110, 3'd3, 8'h04, 1'b1);
    send_word(OP_ENQUEUE, 24'd90, 3'd7, 8'h05, 1'b0);
    send_word(OP_ENQUEUE, '1, 3'd1, 8'h06, 1'b1);
    send_word(OP_ENQUEUE, '0, 3'd4, 8'h07, 1'b0);
    repeat (9) begin
      send_word(OP_ENQUEUE, BLK_W'($urandom), PRIO_W'($urandom_range(0, 7)),
                TAG_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    // A seventeenth word finds the queue full.
    send_word(OP_ENQUEUE, 24'd5, 3'd6, 8'hAA, 1'b1);
    repeat (4) send_word(OP_DISPATCH, '0, '0, '0, 1'b0);

    // Random phases, each under its own settings; the last one runs without idling.
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: begin pol_bit = POL_SSTF; delay_word = DELAY_W'($urandom); gap_pct = 30; enq_pct = 60; end
        1: begin pol_bit = POL_FCFS; delay_word = '0;                gap_pct = 15; enq_pct = 75; end
        2: begin pol_bit = POL_SSTF; delay_word = '1;                gap_pct = 0;  enq_pct = 50; end
        3: begin pol_bit = POL_FCFS; delay_word = DELAY_W'($urandom); gap_pct = 30; enq_pct = 25; end
        4: begin pol_bit = POL_SSTF; delay_word = '0;                gap_pct = 20; enq_pct = 65; end
        default: begin
          pol_bit = POL_SSTF; delay_word = DELAY_W'($urandom); gap_pct = 0; enq_pct = 50;
          quiet_phase = 1'b1;
        end
      endcase
      cluster = BLK_W'($urandom);
      set_config({15'($urandom), pol_bit}, delay_word);
      for (int k = 0; k < 100; k++) begin
        if (k == 50 && !quiet_phase) drain_results();
        else if ($urandom_range(0, 99) < gap_pct) pause_sender($urandom_range(1, 6));
        send_random(enq_pct, cluster);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    $display("Run covered %0d enqueues, %0d refused on a full queue, %0d on an empty queue.",
             sb.n_enq, sb.n_full, sb.n_empty);
    $display("Dispatches: %0d first-come, %0d shortest-seek, over %0d register writes.",
             sb.n_fcfs, sb.n_sstf, sb.n_cfg);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("disk_request_scheduler_core_tb: PASS");
    end else begin
      $display("disk_request_scheduler_core_tb: FAIL");
    end
    $finish;
  end

endmodule
